/* design/fct_pkg.sv */
// Shared types and constants for the six-plane frustum cull tester.
// No dependencies; used by frustum_cull_tester_core.
package fct_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int AXIS_COUNT  = 3;
   localparam int COORD_W     = 16;              // signed Q8.8 center
   localparam int HALF_W      = 15;              // unsigned Q7.8 half size
   localparam int NORM_W      = 16;              // signed Q1.14 normal / Q8.8 d
   localparam int D_SHIFT     = 14;              // d (Q8.8) to dot scale 2^22
   localparam int DOT_W       = COORD_W + NORM_W;            // 32, signed
   localparam int EXT_W       = NORM_W + HALF_W;             // 31, unsigned
   localparam int DOT_SUM_W   = DOT_W + 3;                   // 35, signed
   localparam int EXT_SUM_W   = EXT_W + 2;                   // 33, unsigned
   localparam int TOTAL_W     = DOT_SUM_W + 1;               // 36, signed
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int REQ_DATA_W  = 96;              // 3*16 + 3*15 = 93, byte padded
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 8;

   typedef enum logic [1:0] {
      KIND_POINT  = 2'd0,
      KIND_SPHERE = 2'd1,
      KIND_CUBE   = 2'd2,
      KIND_BOX    = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PLANE_NEAR   = 3'd0,
      CSR_PLANE_FAR    = 3'd1,
      CSR_PLANE_LEFT   = 3'd2,
      CSR_PLANE_RIGHT  = 3'd3,
      CSR_PLANE_TOP    = 3'd4,
      CSR_PLANE_BOTTOM = 3'd5
   } csr_index_type;

   // Packed register layout: nx in the top bits, d in the bottom bits.
   typedef struct packed {
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nz;
      logic signed [NORM_W-1:0] d;
   } plane_type;

   // Magnitude of a Q1.14 normal component; -32768 maps to 0x8000 unsigned.
   function automatic logic [NORM_W-1:0] norm_mag(input logic signed [NORM_W-1:0] n);
      logic [NORM_W-1:0] neg;
      neg = NORM_W'(-n);
      return n[NORM_W-1] ? neg : NORM_W'(n);
   endfunction

endpackage

/* design/frustum_cull_tester_core.sv */
// Top level of the six-plane frustum cull tester: plane registers and the
// four-stage test pipeline. Depends on fct_pkg.
//
// Usage:
//   csr_*  : plane registers 0..5 (near, far, left, right, top, bottom), 64 bits
//            each, packed nx ny nz (Q1.14) and d (Q8.8). Indexes 6 and 7 are
//            ignored. Write only while no transaction is in flight.
//   req_*  : one query per transaction; tuser is the kind (point, sphere, cube,
//            box), tdata the center and half sizes.
//   rsp_*  : one transaction per query, tdata[0] = 1 when all six tests pass.
// Four register stages: input register, 36 parallel multipliers (16x16 dot,
// 16x15 extent), per-plane adder trees, then the sign test and six-way AND
// into the output register. One query is accepted per cycle while the
// pipeline is not stalled. Each stage holds its transaction while the next
// is full, so a stalled receiver first closes the bubbles and then drops
// req_tready; nothing is lost or repeated. Reset empties the pipeline and
// clears all planes to zero, which makes every query pass until planes are
// written.
module frustum_cull_tester_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [fct_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fct_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // center_x[15:0] center_y[31:16] center_z[47:32]
   // half_x[62:48] half_y[77:63] half_z[92:78], zero fill above
   input  logic [fct_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind[1:0]
   input  logic [fct_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // inside_res[0], zero fill above
   output logic [fct_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int NP = fct_pkg::PLANE_COUNT;
   localparam int NA = fct_pkg::AXIS_COUNT;

   // ---------------- plane registers ----------------
   fct_pkg::plane_type planes_ff [NP];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NP; i++) planes_ff[i] <= '0;
      end else if (csr_we) begin
         case (fct_pkg::csr_index_type'(csr_index))
            fct_pkg::CSR_PLANE_NEAR:   planes_ff[0] <= csr_wdata;
            fct_pkg::CSR_PLANE_FAR:    planes_ff[1] <= csr_wdata;
            fct_pkg::CSR_PLANE_LEFT:   planes_ff[2] <= csr_wdata;
            fct_pkg::CSR_PLANE_RIGHT:  planes_ff[3] <= csr_wdata;
            fct_pkg::CSR_PLANE_TOP:    planes_ff[4] <= csr_wdata;
            fct_pkg::CSR_PLANE_BOTTOM: planes_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- stage enables ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_en, s2_en, s3_en, out_en;

   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign s3_en      = !s3_valid_ff || out_en;
   assign s2_en      = !s2_valid_ff || s3_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_tready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff  <= req_tvalid;
         if (s2_en) s2_valid_ff  <= s1_valid_ff;
         if (s3_en) s3_valid_ff  <= s2_valid_ff;
         if (out_en) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- stage 1: input register ----------------
   fct_pkg::kind_type                   s1_kind_ff;
   logic signed [fct_pkg::COORD_W-1:0]  s1_c_ff [NA];
   logic [fct_pkg::HALF_W-1:0]          s1_h_ff [NA];
   logic [fct_pkg::HALF_W-1:0]          hx_in, hy_in, hz_in;
   fct_pkg::kind_type                   kind_in;

   always_comb begin
      kind_in = fct_pkg::kind_type'(req_tuser);
      hx_in   = req_tdata[62:48];
      hy_in   = req_tdata[77:63];
      hz_in   = req_tdata[92:78];
      // a cube uses half_x on all three axes
      if (kind_in == fct_pkg::KIND_CUBE) begin
         hy_in = hx_in;
         hz_in = hx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_kind_ff <= kind_in;
         s1_c_ff[0] <= req_tdata[15:0];
         s1_c_ff[1] <= req_tdata[31:16];
         s1_c_ff[2] <= req_tdata[47:32];
         s1_h_ff[0] <= hx_in;
         s1_h_ff[1] <= hy_in;
         s1_h_ff[2] <= hz_in;
      end
   end

   // ---------------- stage 2: products ----------------
   // dot: n*c per axis; ext: |n|*h per axis, the best-corner offset of a box
   fct_pkg::kind_type                  s2_kind_ff;
   logic [fct_pkg::HALF_W-1:0]         s2_hx_ff;
   logic signed [fct_pkg::DOT_W-1:0]   s2_dot_ff [NP][NA];
   logic [fct_pkg::EXT_W-1:0]          s2_ext_ff [NP][NA];
   logic signed [fct_pkg::DOT_W-1:0]   dot_in [NP][NA];
   logic [fct_pkg::EXT_W-1:0]          ext_in [NP][NA];

   always_comb begin
      for (int i = 0; i < NP; i++) begin
         dot_in[i][0] = fct_pkg::DOT_W'(planes_ff[i].nx) * fct_pkg::DOT_W'(s1_c_ff[0]);
         dot_in[i][1] = fct_pkg::DOT_W'(planes_ff[i].ny) * fct_pkg::DOT_W'(s1_c_ff[1]);
         dot_in[i][2] = fct_pkg::DOT_W'(planes_ff[i].nz) * fct_pkg::DOT_W'(s1_c_ff[2]);
         ext_in[i][0] = fct_pkg::EXT_W'(fct_pkg::norm_mag(planes_ff[i].nx))
                      * fct_pkg::EXT_W'(s1_h_ff[0]);
         ext_in[i][1] = fct_pkg::EXT_W'(fct_pkg::norm_mag(planes_ff[i].ny))
                      * fct_pkg::EXT_W'(s1_h_ff[1]);
         ext_in[i][2] = fct_pkg::EXT_W'(fct_pkg::norm_mag(planes_ff[i].nz))
                      * fct_pkg::EXT_W'(s1_h_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_kind_ff <= s1_kind_ff;
         s2_hx_ff   <= s1_h_ff[0];
         s2_dot_ff  <= dot_in;
         s2_ext_ff  <= ext_in;
      end
   end

   // ---------------- stage 3: per-plane sums ----------------
   logic signed [fct_pkg::DOT_SUM_W-1:0] s3_dot_ff [NP];
   logic [fct_pkg::EXT_SUM_W-1:0]        s3_ext_ff [NP];
   logic signed [fct_pkg::DOT_SUM_W-1:0] dot_sum_in [NP];
   logic [fct_pkg::EXT_SUM_W-1:0]        ext_sum_in [NP];
   logic [fct_pkg::EXT_SUM_W-1:0]        radius_scaled;

   always_comb begin
      radius_scaled = fct_pkg::EXT_SUM_W'(s2_hx_ff) << fct_pkg::D_SHIFT;
      for (int i = 0; i < NP; i++) begin
         dot_sum_in[i] = fct_pkg::DOT_SUM_W'(s2_dot_ff[i][0])
                       + fct_pkg::DOT_SUM_W'(s2_dot_ff[i][1])
                       + fct_pkg::DOT_SUM_W'(s2_dot_ff[i][2])
                       + (fct_pkg::DOT_SUM_W'(planes_ff[i].d) <<< fct_pkg::D_SHIFT);
         case (s2_kind_ff)
            fct_pkg::KIND_POINT:  ext_sum_in[i] = '0;
            fct_pkg::KIND_SPHERE: ext_sum_in[i] = radius_scaled;
            default:              ext_sum_in[i] = fct_pkg::EXT_SUM_W'(s2_ext_ff[i][0])
                                                + fct_pkg::EXT_SUM_W'(s2_ext_ff[i][1])
                                                + fct_pkg::EXT_SUM_W'(s2_ext_ff[i][2]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_dot_ff <= dot_sum_in;
         s3_ext_ff <= ext_sum_in;
      end
   end

   // ---------------- stage 4: sign test into output register ----------------
   logic                                 rsp_inside_ff;
   logic signed [fct_pkg::TOTAL_W-1:0]   total [NP];
   logic [NP-1:0]                        pass;

   always_comb begin
      for (int i = 0; i < NP; i++) begin
         total[i] = fct_pkg::TOTAL_W'(s3_dot_ff[i])
                  + $signed(fct_pkg::TOTAL_W'(s3_ext_ff[i]));
         pass[i]  = !total[i][fct_pkg::TOTAL_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) rsp_inside_ff <= &pass;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(fct_pkg::RSP_DATA_W-1){1'b0}}, rsp_inside_ff};

   // ---------------- assertions ----------------
   a_s2_fill: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_en) |=> s2_valid_ff)
      else $error("stage 2 dropped a transaction");

   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && out_en) |=> rsp_tvalid)
      else $error("output register dropped a transaction");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && s1_valid_ff && s2_valid_ff && s3_valid_ff)
         |-> !req_tready)
      else $error("request accepted into a full, stalled pipeline");

endmodule

/* verif/frustum_cull_checker.sv */
// Scoreboard for frustum_cull_tester_core: mirrors the plane registers from the
// csr port, predicts inside_res for each accepted query and compares responses.
// Depends on fct_pkg.
module frustum_cull_checker
   import fct_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // center_x center_y center_z half_x half_y half_z, from bit 0 up
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // kind
   input  logic [REQ_USER_W-1:0]  req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // inside_res
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   output int                     error_count,
   output int                     pending_count,
   output int                     result_count,
   output int                     inside_count
);

   localparam longint D_SCALE = longint'(1) <<< D_SHIFT;

   plane_type plane_mirror [PLANE_COUNT];
   bit        inside_queue [$];

   // Exact signed distance at scale 2^22; wide enough that nothing wraps.
   function automatic longint plane_distance(plane_type pl, longint px, longint py,
                                             longint pz);
      return longint'(signed'(pl.nx)) * px + longint'(signed'(pl.ny)) * py
           + longint'(signed'(pl.nz)) * pz + longint'(signed'(pl.d)) * D_SCALE;
   endfunction

   function automatic bit cull_passes(kind_type kind, longint cx, longint cy, longint cz,
                                      longint hx, longint hy, longint hz);
      bit     passes;
      bit     corner_hit;
      longint px;
      longint py;
      longint pz;
      passes = 1'b1;
      if (kind == KIND_CUBE) begin
         hy = hx;
         hz = hx;
      end
      foreach (plane_mirror[p]) begin
         case (kind)
            KIND_POINT: begin
               if (plane_distance(plane_mirror[p], cx, cy, cz) < 0) passes = 1'b0;
            end
            KIND_SPHERE: begin
               if (plane_distance(plane_mirror[p], cx, cy, cz) < -hx * D_SCALE)
                  passes = 1'b0;
            end
            default: begin
               // cube or box: some corner must sit on the positive side
               corner_hit = 1'b0;
               for (int c = 0; c < 8; c++) begin
                  px = (c & 1) ? cx + hx : cx - hx;
                  py = (c & 2) ? cy + hy : cy - hy;
                  pz = (c & 4) ? cz + hz : cz - hz;
                  if (plane_distance(plane_mirror[p], px, py, pz) >= 0) corner_hit = 1'b1;
               end
               if (!corner_hit) passes = 1'b0;
            end
         endcase
      end
      return passes;
   endfunction

   always @(posedge clock) begin
      bit expected_inside;
      if (reset) begin
         foreach (plane_mirror[p]) plane_mirror[p] = '0;
         inside_queue.delete();
         error_count = 0;
         result_count = 0;
         inside_count = 0;
      end else begin
         // indexes past the last plane are dropped by the block
         if (csr_we && csr_index < PLANE_COUNT) plane_mirror[csr_index] = csr_wdata;
         if (req_tvalid && req_tready) begin
            inside_queue.push_back(cull_passes(kind_type'(req_tuser),
               longint'(signed'(req_tdata[15:0])),
               longint'(signed'(req_tdata[31:16])),
               longint'(signed'(req_tdata[47:32])),
               longint'(req_tdata[62:48]),
               longint'(req_tdata[77:63]),
               longint'(req_tdata[92:78])));
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (rsp_tdata[0] === 1'b1) inside_count++;
            if (inside_queue.size() == 0) begin
               $error("inside_res: transaction with no query outstanding, expected none, actual %0b",
                      rsp_tdata[0]);
               error_count++;
            end else begin
               expected_inside = inside_queue.pop_front();
               if (rsp_tdata[0] !== expected_inside) begin
                  $error("inside_res mismatch: expected %0b, actual %0b",
                         expected_inside, rsp_tdata[0]);
                  error_count++;
               end
            end
         end
      end
      pending_count = inside_queue.size();
   end

endmodule

/* verif/frustum_cull_tester_core_tb.sv */
// Top of the frustum_cull_tester_core testbench: clock, reset, plane settings and
// query stimulus with random gaps; checking is done by frustum_cull_checker.
// Depends on fct_pkg, frustum_cull_tester_core and frustum_cull_checker.
module frustum_cull_tester_core_tb;
   import fct_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int Q88_ONE     = 256;               // 1.0 in Q8.8
   localparam int NORM_ONE    = 1 << D_SHIFT;      // 1.0 in Q1.14
   localparam int NORM_DIAG   = 11585;             // 1/sqrt(2) in Q1.14
   localparam int BOX_EDGE    = 10 * Q88_ONE;      // axis box spans +/-10.0
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   int error_count;
   int pending_count;
   int result_count;
   int inside_count;

   int          gap_odds = 4;      // 0: no gaps, else one transaction in gap_odds gets one
   int          rsp_stall_left = 0;
   int          queries_sent = 0;
   int          setting_count = 1;
   int unsigned cycle_count = 0;
   plane_type   plane_set [PLANE_COUNT];

   frustum_cull_tester_core u_dut (.*);

   frustum_cull_checker u_checker (.*);

   always #5 clock = ~clock;

   // receiver back-pressure in bursts
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         rsp_tready <= 1'b0;
         rsp_stall_left = $urandom_range(1, 10) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("frustum_cull_tester_core regression: fail");
      $finish;
   end

   function automatic plane_type make_plane(int nx, int ny, int nz, int d);
      return {16'(nx), 16'(ny), 16'(nz), 16'(d)};
   endfunction

   task automatic send_query(kind_type kind, int cx, int cy, int cz, int hx, int hy, int hz);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, 15'(hz), 15'(hy), 15'(hx), 16'(cz), 16'(cy), 16'(cx)};
      do @(posedge clock); while (!req_tready);
      queries_sent++;
   endtask

   task automatic random_queries(int count, int span);
      int coord [AXIS_COUNT];
      int half [AXIS_COUNT];
      for (int n = 0; n < count; n++) begin
         for (int a = 0; a < AXIS_COUNT; a++) begin
            coord[a] = ($urandom_range(0, 9) == 0) ? int'($urandom)
                     : int'($urandom_range(0, 2 * span)) - span;
            half[a]  = ($urandom_range(0, 9) == 0) ? int'($urandom)
                     : int'($urandom_range(0, span / 2));
         end
         send_query(kind_type'($urandom_range(0, 3)), coord[0], coord[1], coord[2],
                    half[0], half[1], half[2]);
      end
   endtask

   // Leaves the request side idle until every response is back.
   task automatic drain_queries();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   // Writes all planes, then junk to the unused indexes, which must not land.
   task automatic load_planes();
      drain_queries();
      for (int i = 0; i < PLANE_COUNT; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= plane_set[i];
         @(posedge clock);
      end
      csr_index <= CSR_SPARE_LO;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_index <= CSR_SPARE_HI;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_we <= 1'b0;
      setting_count++;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset planes: every query passes, whatever the fields
      send_query(KIND_POINT, -32768, 32767, -32768, 32767, 32767, 32767);
      send_query(KIND_SPHERE, 32767, -32768, 32767, 32767, 0, 32767);
      send_query(KIND_CUBE, -32768, -32768, -32768, 32767, 32767, 0);
      send_query(KIND_BOX, 32767, 32767, 32767, 32767, 32767, 32767);
      random_queries(100, 32767);

      // axis-aligned box of +/-10.0
      gap_odds = 3;
      plane_set[CSR_PLANE_NEAR]   = make_plane(0, 0, NORM_ONE, BOX_EDGE);
      plane_set[CSR_PLANE_FAR]    = make_plane(0, 0, -NORM_ONE, BOX_EDGE);
      plane_set[CSR_PLANE_LEFT]   = make_plane(NORM_ONE, 0, 0, BOX_EDGE);
      plane_set[CSR_PLANE_RIGHT]  = make_plane(-NORM_ONE, 0, 0, BOX_EDGE);
      plane_set[CSR_PLANE_TOP]    = make_plane(0, -NORM_ONE, 0, BOX_EDGE);
      plane_set[CSR_PLANE_BOTTOM] = make_plane(0, NORM_ONE, 0, BOX_EDGE);
      load_planes();
      send_query(KIND_POINT, 0, 0, 0, 0, 0, 0);
      send_query(KIND_POINT, BOX_EDGE, 0, 0, 0, 0, 0);          // on the plane
      send_query(KIND_POINT, BOX_EDGE + 1, 0, 0, 0, 0, 0);
      send_query(KIND_POINT, 0, 0, -BOX_EDGE - 1, 0, 0, 0);
      send_query(KIND_POINT, 0, 0, 0, 32767, 32767, 32767);     // halves ignored
      send_query(KIND_SPHERE, BOX_EDGE + 100, 0, 0, 100, 0, 0); // touches at -radius
      send_query(KIND_SPHERE, BOX_EDGE + 100, 0, 0, 99, 0, 0);
      send_query(KIND_SPHERE, 0, 0, 0, 0, 32767, 32767);
      send_query(KIND_CUBE, 3000, 3000, 3000, 440, 0, 0);
      send_query(KIND_CUBE, 3000, 3000, 3000, 439, 32767, 32767);
      send_query(KIND_BOX, 0, 3000, 0, 0, 440, 0);
      send_query(KIND_BOX, 0, 3000, 0, 0, 439, 0);
      // corners past the Q8.8 range stay exact
      send_query(KIND_BOX, 32767, 32767, 32767, 32767, 32767, 32767);
      send_query(KIND_CUBE, -32768, -32768, -32768, 32767, 0, 0);
      send_query(KIND_POINT, 32767, 32767, 32767, 0, 0, 0);
      random_queries(300, 4000);

      // perspective frustum looking down +z, near 1.0, far 100.0
      gap_odds = 8;
      plane_set[CSR_PLANE_NEAR]   = make_plane(0, 0, NORM_ONE, -Q88_ONE);
      plane_set[CSR_PLANE_FAR]    = make_plane(0, 0, -NORM_ONE, 100 * Q88_ONE);
      plane_set[CSR_PLANE_LEFT]   = make_plane(NORM_DIAG, 0, NORM_DIAG, 0);
      plane_set[CSR_PLANE_RIGHT]  = make_plane(-NORM_DIAG, 0, NORM_DIAG, 0);
      plane_set[CSR_PLANE_TOP]    = make_plane(0, -NORM_DIAG, NORM_DIAG, 0);
      plane_set[CSR_PLANE_BOTTOM] = make_plane(0, NORM_DIAG, NORM_DIAG, 0);
      load_planes();
      random_queries(300, 28000);

      // frustum normals jittered, offsets replaced by random values
      gap_odds = 2;
      foreach (plane_set[i]) begin
         plane_set[i].nx += 16'($urandom_range(0, 4000) - 2000);
         plane_set[i].ny += 16'($urandom_range(0, 4000) - 2000);
         plane_set[i].nz += 16'($urandom_range(0, 4000) - 2000);
         plane_set[i].d   = 16'($urandom_range(0, 5120) - 2560);
      end
      load_planes();
      random_queries(250, 20000);

      // extreme words: passes when the coordinate sum lies within about +/-64.0
      gap_odds = 5;
      plane_set[CSR_PLANE_NEAR]   = make_plane(32767, 32767, 32767, 32767);
      plane_set[CSR_PLANE_FAR]    = make_plane(-32768, -32768, -32768, 32767);
      plane_set[CSR_PLANE_LEFT]   = make_plane(32767, 32767, 32767, 32767);
      plane_set[CSR_PLANE_RIGHT]  = make_plane(-32768, -32768, -32768, 32767);
      plane_set[CSR_PLANE_TOP]    = make_plane(32767, 32767, 32767, 32767);
      plane_set[CSR_PLANE_BOTTOM] = make_plane(-32768, -32768, -32768, 32767);
      load_planes();
      random_queries(150, 32767);

      // raw random words
      gap_odds = 6;
      foreach (plane_set[i]) plane_set[i] = {$urandom, $urandom};
      load_planes();
      random_queries(150, 32767);

      // back to the axis box, no gaps on either side
      gap_odds = 0;
      plane_set[CSR_PLANE_NEAR]   = make_plane(0, 0, NORM_ONE, BOX_EDGE);
      plane_set[CSR_PLANE_FAR]    = make_plane(0, 0, -NORM_ONE, BOX_EDGE);
      plane_set[CSR_PLANE_LEFT]   = make_plane(NORM_ONE, 0, 0, BOX_EDGE);
      plane_set[CSR_PLANE_RIGHT]  = make_plane(-NORM_ONE, 0, 0, BOX_EDGE);
      plane_set[CSR_PLANE_TOP]    = make_plane(0, -NORM_ONE, 0, BOX_EDGE);
      plane_set[CSR_PLANE_BOTTOM] = make_plane(0, NORM_ONE, 0, BOX_EDGE);
      load_planes();
      random_queries(200, 4000);

      drain_queries();
      repeat (8) @(posedge clock);
      $display("%0d queries over %0d plane settings (reset, box, frustum, jittered, extreme, random)",
               queries_sent, setting_count);
      $display("%0d responses checked: %0d inside, %0d culled",
               result_count, inside_count, result_count - inside_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("frustum_cull_tester_core regression: pass");
      end else begin
         $display("frustum_cull_tester_core regression: fail");
      end
      $finish;
   end

endmodule
